[src/fire_buffer_smoothing_stencil_macros.svh]
// Assertion macros used by the checker file of the smoothing stencil.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FIRE_BUFFER_SMOOTHING_STENCIL_MACROS_SVH
`define FIRE_BUFFER_SMOOTHING_STENCIL_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FBSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbss check failed");

// Next-cycle implication, disabled while reset is held.
`define FBSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbss check failed");

`endif

[src/fbss_pkg.sv]
// ----------------------------------------------------------------------------
// fbss_pkg
// Shared widths and constants of the fire buffer smoothing stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package fbss_pkg;

    localparam int DEF_ROW_WIDTH = 320;

    localparam int PIXEL_W = 8;    // buffer byte
    localparam int INT_W   = 5;    // intensity field, bits 4..0
    localparam int COLOR_W = PIXEL_W - INT_W;

    localparam int NB_SUM_W = 7;   // left + right + up, at most 93
    localparam int SUM_W    = 10;  // full weighted sum, at most 961

    localparam logic [INT_W-1:0] CENTRE_WEIGHT = 5'd25;
    localparam logic [INT_W-1:0] INT_MIN       = 5'd2;
    localparam logic [INT_W-1:0] INT_MAX       = 5'd31;

endpackage

`default_nettype wire

[src/fbss_ram.sv]
// ----------------------------------------------------------------------------
// fbss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read word until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/fire_buffer_smoothing_stencil.sv]
// ----------------------------------------------------------------------------
// fire_buffer_smoothing_stencil
// Smoothing pass of the fire effect over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and gives one smoothed word per clock while
// the output is not stalled. The accept cycle reads the row-above intensity
// from a ROW_WIDTH x 5-bit line store RAM; the compute stage then forms
// (2*left + 2*right + 2*up + 25*centre)/32 clamped to 2..31 and, on advance,
// writes it back to the line store, loads the output register and feeds the
// left-neighbor register, so the throughput of one word per cycle is set by
// that combinational add and clamp loop. The line store needs no clearing after
// reset: the top row writes every entry before any read value is used.
// in_stall rises only while the output word is held by out_stall.
`default_nettype none

module fire_buffer_smoothing_stencil
    import fbss_pkg::*;
#(
    parameter int ROW_WIDTH = fbss_pkg::DEF_ROW_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [fbss_pkg::PIXEL_W-1:0] centre_pixel,
    input  wire logic [fbss_pkg::PIXEL_W-1:0] right_pixel,
    input  wire logic                         frame_start,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [fbss_pkg::PIXEL_W-1:0] smoothed_pixel
);

    localparam int COL_W = $clog2(ROW_WIDTH);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_WIDTH - 1);

    // stream position
    logic [COL_W-1:0]   col_reg,   col_next;
    logic               first_reg, first_next;
    logic [COL_W-1:0]   cur_col;
    logic               cur_first;

    // compute stage
    logic               s1_valid_reg, s1_valid_next;
    logic [PIXEL_W-1:0] s1_centre_reg;
    logic [INT_W-1:0]   s1_right_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_first_reg;
    logic [INT_W-1:0]   left_reg;

    // output stage
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] out_pixel_reg;

    logic               in_accept;
    logic               s1_advance;
    logic [INT_W-1:0]   up_int;
    logic [INT_W-1:0]   up_term, left_term, right_term;
    logic [NB_SUM_W-1:0] nb_sum;
    logic [SUM_W-1:0]   total;
    logic [INT_W-1:0]   quot;
    logic [INT_W-1:0]   new_int;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // A frame start restarts at column 0 of the top row.
    assign cur_col   = frame_start ? '0 : col_reg;
    assign cur_first = frame_start ? 1'b1 : first_reg;

    always_comb
    begin
        col_next   = col_reg;
        first_next = first_reg;
        if (in_accept)
        begin
            if (cur_col == LAST_COL)
            begin
                col_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                col_next   = cur_col + COL_W'(1);
                first_next = cur_first;
            end
        end
    end

    fbss_ram #(
        .WIDTH (INT_W),
        .DEPTH (ROW_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (new_int),
        .rd_en   (in_accept),
        .rd_addr (cur_col),
        .rd_data (up_int)
    );

    // Drop the neighbors that fall outside the buffer.
    assign up_term    = s1_first_reg ? '0 : up_int;
    assign left_term  = (s1_col_reg == '0) ? '0 : left_reg;
    assign right_term = (s1_col_reg == LAST_COL) ? '0 : s1_right_reg;

    assign nb_sum = NB_SUM_W'(left_term) + NB_SUM_W'(right_term) + NB_SUM_W'(up_term);
    assign total  = SUM_W'({nb_sum, 1'b0})
                  + SUM_W'(s1_centre_reg[INT_W-1:0]) * SUM_W'(CENTRE_WEIGHT);
    assign quot   = total[SUM_W-1 -: INT_W];

    always_comb
    begin
        if (quot < INT_MIN)
        begin
            new_int = INT_MIN;
        end
        else if (quot > INT_MAX)
        begin
            new_int = INT_MAX;
        end
        else
        begin
            new_int = quot;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_reg     <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            first_reg     <= first_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                left_reg <= new_int;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_centre_reg <= centre_pixel;
            s1_right_reg  <= right_pixel[INT_W-1:0];
            s1_col_reg    <= cur_col;
            s1_first_reg  <= cur_first;
        end
        if (s1_advance)
        begin
            out_pixel_reg <= {s1_centre_reg[PIXEL_W-1 -: COLOR_W], new_int};
        end
    end

    assign out_valid      = out_valid_reg;
    assign smoothed_pixel = out_pixel_reg;

endmodule

`default_nettype wire

[src/fbss_checker.sv]
// ----------------------------------------------------------------------------
// fbss_checker
// Port-level checks of the smoothing stencil, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fire_buffer_smoothing_stencil_macros.svh"

module fbss_checker
    import fbss_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic [fbss_pkg::PIXEL_W-1:0] centre_pixel,
    input  wire logic [fbss_pkg::PIXEL_W-1:0] right_pixel,
    input  wire logic                         frame_start,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [fbss_pkg::PIXEL_W-1:0] smoothed_pixel
);

    // A stalled output word stays put.
    `FBSS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(smoothed_pixel))

    // Intensity never drops below the floor.
    `FBSS_ASSERT_IMP(a_int_floor, out_valid, smoothed_pixel[INT_W-1:0] >= INT_MIN)

    // Input back pressure comes only from a held output word.
    `FBSS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // A fresh output word traces back through the compute stage to an accepted input word.
    `FBSS_ASSERT_IMP(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind fire_buffer_smoothing_stencil fbss_checker u_fbss_checker (.*);

`default_nettype wire

[tb/tb_fire_buffer_smoothing_stencil.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fire_buffer_smoothing_stencil
// Self-checking bench for the fire buffer smoothing stencil.
// ----------------------------------------------------------------------------
// Streams pixel words in raster order through the block: first a handful of
// hand-picked words (field extremes, start without a frame start, a frame
// start in mid-row), then random buffer passes that mostly span several rows,
// with right_pixel taken from the next word as a frame buffer would give it.
// A scoreboard predicts every smoothed word from its own copy of the column,
// top-row flag, left intensity and line store, and checks words in order.
// Both sides idle at random; the receiver holds off once for a long stretch
// and the sender once drains the block before going on.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fire_buffer_smoothing_stencil;

    localparam int ROW_W      = fbss_pkg::DEF_ROW_WIDTH;
    localparam int PW         = fbss_pkg::PIXEL_W;
    localparam int IW         = fbss_pkg::INT_W;
    localparam int NUM_RANDOM = 1550;
    localparam int PAUSE_AT   = 1000;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 150;

    // Predicts smoothed words and checks them in arrival order.
    class smooth_scoreboard;
        int            column;
        bit            top_row;
        bit [IW-1:0]   left_int;
        bit [IW-1:0]   row_above [ROW_W];
        bit [PW-1:0]   expected_q [$];
        int            errors;

        function new();
            column   = 0;
            top_row  = 1'b1;
            left_int = '0;
            errors   = 0;
        endfunction

        function void note_pixel(bit [PW-1:0] centre, bit [PW-1:0] right, bit fs);
            int unsigned total;
            total = 0;
            if (fs)
            begin
                column  = 0;
                top_row = 1'b1;
            end
            if (column > 0)
                total += 2 * left_int;
            if (column < ROW_W - 1)
                total += 2 * right[IW-1:0];
            if (!top_row)
                total += 2 * row_above[column];
            total += 25 * centre[IW-1:0];
            total = total / 32;
            if (total > 31)
                total = 31;
            if (total < 2)
                total = 2;
            expected_q.push_back({centre[PW-1:IW], total[IW-1:0]});
            row_above[column] = total[IW-1:0];
            left_int = total[IW-1:0];
            column++;
            if (column >= ROW_W)
            begin
                column  = 0;
                top_row = 1'b0;
            end
        endfunction

        function void check_pixel(bit [PW-1:0] got);
            bit [PW-1:0] want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: smoothed_pixel %02h arrived with no word expected",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: smoothed_pixel mismatch: expected %02h, actual %02h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [PW-1:0] centre_pixel;
    logic [PW-1:0] right_pixel;
    logic          frame_start;
    logic          out_valid;
    logic          out_stall;
    logic [PW-1:0] smoothed_pixel;

    smooth_scoreboard sb = new();
    int idle_cycles;

    fire_buffer_smoothing_stencil #(
        .ROW_WIDTH(ROW_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .centre_pixel(centre_pixel),
        .right_pixel(right_pixel),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .smoothed_pixel(smoothed_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sample both handshakes and run the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_pixel(centre_pixel, right_pixel, frame_start);
            if (out_valid && !out_stall)
                sb.check_pixel(smoothed_pixel);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PW-1:0] pick_pixel(int mode);
        logic [PW-1:0] p;
        p = PW'($urandom_range(0, 255));
        case (mode)
            1: p[IW-1:0] = IW'($urandom_range(24, 31));   // hot
            2: p[IW-1:0] = IW'($urandom_range(0, 4));     // cold
            default: ;
        endcase
        return p;
    endfunction

    // Offer one word, hold it until taken, then idle for the given gap and, if asked, drain.
    task automatic send_pixel(input logic [PW-1:0] c, input logic [PW-1:0] r,
                              input logic fs, input int gap, input bit drain);
        in_valid     <= 1'b1;
        centre_pixel <= c;
        right_pixel  <= r;
        frame_start  <= fs;
        do
            @(posedge clk);
        while (in_stall);
        if (gap > 0 || drain)
            in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (drain)
        begin
            // let the monitor note the last word before counting
            @(posedge clk);
            while (sb.pending() != 0)
                @(posedge clk);
        end
    endtask

    // Result side: ready stretches and stalls, one long hold-off.
    initial
    begin : result_side
        int  ready_len;
        int  hold_len;
        int  rx_cycle;
        bit  long_done;
        int  r;
        rx_cycle  = 0;
        long_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            ready_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150)
                                                    : $urandom_range(1, 8);
            out_stall <= 1'b0;
            repeat (ready_len) @(posedge clk);
            rx_cycle += ready_len;
            r = $urandom_range(0, 99);
            if (!long_done && rx_cycle >= 700)
            begin
                hold_len  = LONG_HOLD;
                long_done = 1'b1;
            end
            else if (r < 60)
                hold_len = 0;
            else if (r < 90)
                hold_len = $urandom_range(1, 3);
            else
                hold_len = $urandom_range(10, 40);
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                rx_cycle += hold_len;
            end
        end
    end

    // Source side: directed words, then random buffer passes.
    initial
    begin : source_side
        logic [PW-1:0] dir_c [20];
        logic [PW-1:0] dir_r [20];
        logic          dir_fs [20];
        logic [PW-1:0] cur;
        logic [PW-1:0] nxt;
        logic [PW-1:0] rgt;
        int            sent;
        int            pass_len;
        int            mode;
        int            col;
        bit            burst;

        dir_c  = '{8'h00, 8'hFF, 8'h1F, 8'hE0, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h01, 8'h20,
                   8'h7F, 8'h80, 8'hFF, 8'h3F, 8'hC0, 8'h9F, 8'h60, 8'h1E, 8'hFF, 8'h00};
        dir_r  = '{8'h00, 8'hFF, 8'h1F, 8'hE0, 8'h5A, 8'hA5, 8'hFF, 8'h00, 8'hFE, 8'h1F,
                   8'h80, 8'h7F, 8'hFF, 8'h00, 8'h3F, 8'hC0, 8'h9F, 8'h60, 8'hFF, 8'h00};
        // no frame start at first: stream starts at column 0 of the top row
        dir_fs = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                   1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

        idle_cycles  = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        centre_pixel <= '0;
        right_pixel  <= '0;
        frame_start  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_c[i])
            send_pixel(dir_c[i], dir_r[i], dir_fs[i], pick_gap(1'b0), 1'b0);

        sent = 0;
        while (sent < NUM_RANDOM)
        begin
            // mostly passes of several rows; some short, broken passes
            pass_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
                                                   : $urandom_range(640, 1000);
            mode  = $urandom_range(0, 2);
            burst = ($urandom_range(0, 3) == 0);
            col   = 0;
            nxt   = pick_pixel(mode);
            for (int k = 0; k < pass_len && sent < NUM_RANDOM; k++)
            begin
                cur = nxt;
                if ($urandom_range(0, 9) == 0)
                    mode = $urandom_range(0, 2);
                nxt = pick_pixel(mode);
                // right neighbor is the next raw word, except some noise
                rgt = ($urandom_range(0, 9) == 0 || col == ROW_W - 1)
                      ? pick_pixel(0) : nxt;
                if (col == ROW_W - 1)
                    nxt = pick_pixel(mode);
                if (k % 100 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                sent++;
                send_pixel(cur, rgt, (k == 0), pick_gap(burst), (sent == PAUSE_AT));
                col = (col == ROW_W - 1) ? 0 : col + 1;
            end
        end

        in_valid <= 1'b0;
        // let the monitor note the last word before counting
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
